// ===== hdl/dole_pkg.sv =====
`timescale 1ns / 1ps

package dole_pkg;

  // payload types shared by the channels and the core
  typedef logic [7:0]  byte_t;
  typedef logic [31:0] word_t;
  typedef logic [3:0]  kind_t;

  // default sizes of the lease record stores
  localparam int DNS_SLOTS_DEF    = 4;
  localparam int DOMAIN_BYTES_DEF = 32;

  localparam word_t DEFAULT_LEASE_RESET = 32'd86400;

  // option codes
  localparam byte_t OPT_PAD      = 8'd0;
  localparam byte_t OPT_MASK     = 8'd1;
  localparam byte_t OPT_ROUTER   = 8'd3;
  localparam byte_t OPT_DNS      = 8'd6;
  localparam byte_t OPT_DOMAIN   = 8'd15;
  localparam byte_t OPT_LEASE    = 8'd51;
  localparam byte_t OPT_MSG_TYPE = 8'd53;
  localparam byte_t OPT_SERVER   = 8'd54;
  localparam byte_t OPT_RENEW    = 8'd58;
  localparam byte_t OPT_REBIND   = 8'd59;
  localparam byte_t OPT_END      = 8'd255;

  // record kinds
  localparam kind_t KIND_MSG_TYPE  = 4'd0;
  localparam kind_t KIND_MASK      = 4'd1;
  localparam kind_t KIND_ROUTER    = 4'd2;
  localparam kind_t KIND_SERVER    = 4'd3;
  localparam kind_t KIND_LEASE     = 4'd4;
  localparam kind_t KIND_RENEW     = 4'd5;
  localparam kind_t KIND_REBIND    = 4'd6;
  localparam kind_t KIND_DNS_COUNT = 4'd7;
  localparam kind_t KIND_DNS0      = 4'd8;
  localparam kind_t KIND_DOM_LEN   = 4'd12;
  localparam kind_t KIND_DOM_BYTE  = 4'd13;

  // option walk phase
  typedef enum logic [3:0] {
    PH_CODE = 4'b0001,
    PH_LEN  = 4'b0010,
    PH_DATA = 4'b0100,
    PH_DONE = 4'b1000
  } phase_t;

  // block mode: parsing, filling in defaults or emitting the record run
  typedef enum logic [5:0] {
    M_PARSE = 6'b000001,
    M_FIN   = 6'b000010,
    M_FIX   = 6'b000100,
    M_DNS   = 6'b001000,
    M_DLEN  = 6'b010000,
    M_DOM   = 6'b100000
  } mode_t;

endpackage

// ===== hdl/dole_channels.sv =====
`timescale 1ns / 1ps

// options byte stream
interface dole_opt_if;
  logic            valid;
  logic            ready;
  dole_pkg::byte_t option_byte;
  logic            last_byte;
  modport source (output valid, output option_byte, output last_byte, input ready);
  modport sink (input valid, input option_byte, input last_byte, output ready);
endinterface

// lease record results
interface dole_rec_if;
  logic            valid;
  logic            ready;
  dole_pkg::kind_t record_kind;
  dole_pkg::word_t record_value;
  logic            last_record;
  modport source (output valid, output record_kind, output record_value,
                  output last_record, input ready);
  modport sink (input valid, input record_kind, input record_value,
                input last_record, output ready);
endinterface

// default lease register write
interface dole_cfg_if;
  logic            valid;
  logic            ready;
  dole_pkg::word_t default_lease_seconds;
  modport source (output valid, output default_lease_seconds, input ready);
  modport sink (input valid, input default_lease_seconds, output ready);
endinterface

// ===== hdl/dhcp_option_lease_extractor.sv =====
`timescale 1ns / 1ps

// dhcp options walker and lease record keeper
// options: one byte of the options field per transaction, last_byte on the final one.
//   bytes are taken one per cycle while the block is parsing.
// cfg: writes the default lease register; always ready, write only while idle.
// records: the record run, one kind/value transaction per entry, last_record on the
//   final one. after the last byte is accepted the defaults step (M_FIN) fills in default
//   times, then the run of 9 + dns_used + domain_length records leaves at one per cycle
//   from the output register while the receiver is ready; M_FIX loads the first record.
// options.ready is low from the last byte until the final record is loaded into the
//   output register, so no bytes of a new block are taken while a run is open;
//   the final record may still wait in the output register while new bytes flow in.
// a stalled receiver holds the output register and the record sequencer in place.
// dns servers and domain name live in two small synchronous memories, each split into
//   an active half (read by the run) and a staging half (written while parsing);
//   committing flips the half (a domain only if it fits), so no copy pass is needed.
// reset: parser back to expecting a code, lease record cleared, default lease 86400.
//   the memories are not cleared; only committed entries are ever read.
module dhcp_option_lease_extractor #(
  parameter int DNS_SLOTS    = dole_pkg::DNS_SLOTS_DEF,
  parameter int DOMAIN_BYTES = dole_pkg::DOMAIN_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  dole_opt_if.sink   options,
  dole_cfg_if.sink   cfg,
  dole_rec_if.source records
);
  import dole_pkg::*;

  localparam int DNS_AW = (DNS_SLOTS > 1) ? $clog2(DNS_SLOTS) : 1;
  localparam int DNS_CW = $clog2(DNS_SLOTS + 1);
  localparam int DOM_AW = $clog2(DOMAIN_BYTES);
  localparam int IDX_W  = DOM_AW;

  // parser state
  phase_t      phase, phase_next;
  byte_t       cur_code, cur_code_next;
  byte_t       bytes_left, bytes_left_next;
  byte_t       data_index, data_index_next;
  word_t       acc, acc_next;
  word_t       head_word, head_next;
  byte_t       first_data, first_next;

  // lease record
  byte_t       message_type;
  logic        type_seen;
  word_t       net_mask, router_addr, server_addr;
  word_t       lease, renew, rebind;
  logic [DNS_CW-1:0] dns_used;
  logic        dns_bank;
  logic [DOM_AW-1:0] domain_length;
  logic        dom_bank;
  word_t       default_lease;

  // memories: two halves each, active half picked by the bank bit
  word_t dns_mem [2**(DNS_AW+1)];
  byte_t dom_mem [2**(DOM_AW+1)];
  word_t dns_rd;
  byte_t dom_rd;
  logic  dns_we, dom_we;

  // commit of a finished option
  logic  commit;
  byte_t commit_len;
  logic [DNS_CW-1:0] dns_cnt;

  // run sequencer and output register
  mode_t      mode, mode_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic       load;
  kind_t      item_kind;
  word_t      item_value;
  logic       item_last;
  logic       rec_valid;
  kind_t      rec_kind;
  word_t      rec_value;
  logic       rec_last;

  // default times
  word_t       lease_eff;
  logic [34:0] lease_x7;

  logic in_acc;

  assign options.ready = (mode == M_PARSE);
  assign in_acc        = options.valid & options.ready;
  assign cfg.ready     = 1'b1;

  // byte walk
  always_comb begin
    phase_next      = phase;
    cur_code_next   = cur_code;
    bytes_left_next = bytes_left;
    data_index_next = data_index;
    acc_next        = acc;
    head_next       = head_word;
    first_next      = first_data;
    commit          = 1'b0;
    commit_len      = data_index;
    dns_we          = 1'b0;
    dom_we          = 1'b0;
    if (in_acc) begin
      case (phase)
        PH_CODE: begin
          if (options.option_byte == OPT_END) begin
            phase_next = PH_DONE;
          end else if (options.option_byte != OPT_PAD) begin
            cur_code_next = options.option_byte;
            phase_next    = PH_LEN;
          end
        end
        PH_LEN: begin
          bytes_left_next = options.option_byte;
          data_index_next = '0;
          acc_next        = '0;
          head_next       = '0;
          first_next      = '0;
          if (options.option_byte == 8'd0) begin
            commit     = 1'b1;
            commit_len = '0;
            phase_next = PH_CODE;
          end else begin
            phase_next = PH_DATA;
          end
        end
        PH_DATA: begin
          if (data_index == 8'd0) first_next = options.option_byte;
          acc_next = {acc[23:0], options.option_byte};
          if (data_index == 8'd3) head_next = acc_next;
          // staging halves only matter for their own option
          dns_we = (cur_code == OPT_DNS) && (data_index[1:0] == 2'b11)
                   && ({2'b00, data_index[7:2]} < 8'(DNS_SLOTS));
          dom_we = (cur_code == OPT_DOMAIN) && ({1'b0, data_index} < 9'(DOMAIN_BYTES));
          if (data_index != 8'hff) data_index_next = data_index + 8'd1;
          bytes_left_next = bytes_left - 8'd1;
          if (bytes_left_next == 8'd0) begin
            commit     = 1'b1;
            commit_len = data_index_next;
            phase_next = PH_CODE;
          end
        end
        PH_DONE: begin
        end
        default: phase_next = PH_CODE;
      endcase
      // end of block: walk restarts, unfinished option is dropped
      if (options.last_byte) begin
        phase_next      = PH_CODE;
        bytes_left_next = '0;
        data_index_next = '0;
        acc_next        = '0;
      end
    end
  end

  assign dns_cnt = ({2'b00, commit_len[7:2]} > 8'(DNS_SLOTS)) ? DNS_CW'(DNS_SLOTS)
                                                               : DNS_CW'(commit_len[7:2]);

  // defaults filled in the cycle after the last byte
  assign lease_eff = (lease == '0) ? default_lease : lease;
  assign lease_x7  = {lease_eff, 3'b000} - {3'b000, lease_eff};

  // record run sequencer
  assign load = (mode inside {M_FIX, M_DNS, M_DLEN, M_DOM}) && (!rec_valid || records.ready);

  always_comb begin
    mode_next  = mode;
    idx_next   = idx;
    item_kind  = KIND_MSG_TYPE;
    item_value = '0;
    item_last  = 1'b0;
    case (mode)
      M_PARSE: begin
        if (in_acc && options.last_byte) mode_next = M_FIN;
      end
      M_FIN: begin
        mode_next = M_FIX;
        idx_next  = '0;
      end
      M_FIX: begin
        case (idx[2:0])
          3'd0: begin item_kind = KIND_MSG_TYPE;  item_value = {24'd0, message_type}; end
          3'd1: begin item_kind = KIND_MASK;      item_value = net_mask; end
          3'd2: begin item_kind = KIND_ROUTER;    item_value = router_addr; end
          3'd3: begin item_kind = KIND_SERVER;    item_value = server_addr; end
          3'd4: begin item_kind = KIND_LEASE;     item_value = lease; end
          3'd5: begin item_kind = KIND_RENEW;     item_value = renew; end
          3'd6: begin item_kind = KIND_REBIND;    item_value = rebind; end
          default: begin
            item_kind  = KIND_DNS_COUNT;
            item_value = 32'(dns_used);
          end
        endcase
        if (load) begin
          if (idx[2:0] == 3'd7) begin
            idx_next  = '0;
            mode_next = (dns_used != '0) ? M_DNS : M_DLEN;
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end
      M_DNS: begin
        item_kind  = kind_t'(KIND_DNS0 + idx);
        item_value = dns_rd;
        if (load) begin
          if (((IDX_W+1)'(idx) + 1'b1) < (IDX_W+1)'(dns_used)) begin
            idx_next = idx + 1'b1;
          end else begin
            idx_next  = '0;
            mode_next = M_DLEN;
          end
        end
      end
      M_DLEN: begin
        item_kind  = KIND_DOM_LEN;
        item_value = 32'(domain_length);
        item_last  = (domain_length == '0);
        if (load) begin
          idx_next  = '0;
          mode_next = (domain_length != '0) ? M_DOM : M_PARSE;
        end
      end
      M_DOM: begin
        item_kind  = KIND_DOM_BYTE;
        item_value = {24'd0, dom_rd};
        item_last  = (IDX_W'(idx + 1'b1) == domain_length);
        if (load) begin
          if (item_last) begin
            mode_next = M_PARSE;
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end
      default: mode_next = M_PARSE;
    endcase
  end

  // memories: write from the parser, read addressed by the next sequencer index
  always_ff @(posedge clk) begin
    if (dns_we) dns_mem[{~dns_bank, data_index[DNS_AW+1:2]}] <= acc_next;
    dns_rd <= dns_mem[{dns_bank, idx_next[DNS_AW-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (dom_we) dom_mem[{~dom_bank, data_index[DOM_AW-1:0]}] <= options.option_byte;
    dom_rd <= dom_mem[{dom_bank, idx_next[DOM_AW-1:0]}];
  end

  // parser registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_CODE;
      cur_code   <= '0;
      bytes_left <= '0;
      data_index <= '0;
      acc        <= '0;
      head_word  <= '0;
      first_data <= '0;
    end else begin
      phase      <= phase_next;
      cur_code   <= cur_code_next;
      bytes_left <= bytes_left_next;
      data_index <= data_index_next;
      acc        <= acc_next;
      head_word  <= head_next;
      first_data <= first_next;
    end
  end

  // lease record: option commits while parsing, defaults after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      message_type  <= '0;
      type_seen     <= 1'b0;
      net_mask      <= '0;
      router_addr   <= '0;
      server_addr   <= '0;
      lease         <= '0;
      renew         <= '0;
      rebind        <= '0;
      dns_used      <= '0;
      dns_bank      <= 1'b0;
      domain_length <= '0;
      dom_bank      <= 1'b0;
    end else begin
      if (commit) begin
        case (cur_code)
          OPT_MSG_TYPE: begin
            if (!type_seen) begin
              type_seen    <= 1'b1;
              message_type <= (commit_len != 8'd0) ? first_next : 8'd0;
            end
          end
          OPT_MASK:   if (commit_len == 8'd4) net_mask <= head_next;
          OPT_ROUTER: if (commit_len >= 8'd4) router_addr <= head_next;
          OPT_SERVER: if (commit_len == 8'd4) server_addr <= head_next;
          OPT_LEASE:  if (commit_len == 8'd4) lease <= head_next;
          OPT_RENEW:  if (commit_len == 8'd4) renew <= head_next;
          OPT_REBIND: if (commit_len == 8'd4) rebind <= head_next;
          OPT_DNS: begin
            dns_used <= dns_cnt;
            dns_bank <= ~dns_bank;
          end
          OPT_DOMAIN: begin
            if ({1'b0, commit_len} < 9'(DOMAIN_BYTES)) begin
              domain_length <= DOM_AW'(commit_len);
              dom_bank      <= ~dom_bank;
            end
          end
          default: begin
          end
        endcase
      end
      if (mode == M_FIN) begin
        lease <= lease_eff;
        if (renew == '0) renew <= {1'b0, lease_eff[31:1]};
        if (rebind == '0) rebind <= lease_x7[34:3];
      end
      // message type belongs to one block only
      if (load && item_last) begin
        message_type <= '0;
        type_seen    <= 1'b0;
      end
    end
  end

  // default lease register
  always_ff @(posedge clk) begin
    if (rst) begin
      default_lease <= DEFAULT_LEASE_RESET;
    end else if (cfg.valid && cfg.ready) begin
      default_lease <= cfg.default_lease_seconds;
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= M_PARSE;
      idx       <= '0;
      rec_valid <= 1'b0;
    end else begin
      mode <= mode_next;
      idx  <= idx_next;
      if (load) begin
        rec_valid <= 1'b1;
      end else if (records.ready) begin
        rec_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rec_kind  <= item_kind;
      rec_value <= item_value;
      rec_last  <= item_last;
    end
  end

  assign records.valid        = rec_valid;
  assign records.record_kind  = rec_kind;
  assign records.record_value = rec_value;
  assign records.last_record  = rec_last;

  // a last byte always opens the run with the defaults cycle
  a_last_to_fin: assert property (@(posedge clk) disable iff (rst)
    (in_acc && options.last_byte) |=> (mode == M_FIN))
    else $error("last byte did not start the record run");

  a_fin_once: assert property (@(posedge clk) disable iff (rst)
    (mode == M_FIN) |=> (mode == M_FIX))
    else $error("defaults cycle not followed by the fixed records");

  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    (rec_valid && rec_last) |-> (rec_kind == KIND_DOM_LEN || rec_kind == KIND_DOM_BYTE))
    else $error("run closed on a record that cannot be final");

  a_dns_bound: assert property (@(posedge clk) disable iff (rst)
    (32'(dns_used) <= 32'(DNS_SLOTS)))
    else $error("dns count exceeds the slots");

  a_no_input_in_run: assert property (@(posedge clk) disable iff (rst)
    (load && !item_last) |=> !options.ready)
    else $error("input accepted while the record run is open");

endmodule
